// File: hw/rtl/nrc_pkg.sv
// Shared types and constants for the NTP response checker.
package nrc_pkg;

  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] PKT_LEN = COUNT_W'(48);
  localparam logic [COUNT_W-1:0] TS_FIRST = COUNT_W'(40);
  localparam logic [COUNT_W-1:0] TS_LAST = COUNT_W'(43);
  localparam logic [COUNT_W-1:0] HDR_POS = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] STRATUM_POS = COUNT_W'(1);

  localparam logic [31:0] UNIX_EPOCH_OFFSET = 32'd2208988800;
  localparam int unsigned ZONE_W = 17;

  localparam logic [2:0] MODE_SERVER = 3'd4;
  localparam logic [2:0] MIN_VERSION = 3'd3;
  localparam logic [1:0] LEAP_ALARM = 2'd3;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_SHORT = 3'd1,
    ST_MODE = 3'd2,
    ST_VERSION = 3'd3,
    ST_LEAP = 3'd4,
    ST_STRATUM = 3'd5,
    ST_ZERO_TS = 3'd6
  } status_t;

  typedef struct packed {
    logic        full;
    logic [7:0]  header;
    logic [7:0]  stratum;
    logic [31:0] timestamp;
  } pkt_rec_t;

endpackage

// File: hw/rtl/ntp_response_checker_unit.sv
// Top level of the NTP server response checker.
// Takes one payload byte per beat and gives one result beat for each byte marked
// last. A byte is accepted every cycle while the result side keeps up; the result
// of a packet is carried through a packet record register and the result register.
// Each stage holds one beat, so the input stalls only when both are full. The zone
// offset is written on the config channel, which is always ready.
module ntp_response_checker_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  payload_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        time_valid,
  output logic [2:0]                  check_status,
  output logic [31:0]                 local_unix_seconds,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic signed [nrc_pkg::ZONE_W-1:0] zone_offset_seconds
);

  logic [nrc_pkg::ZONE_W-1:0] zone;
  logic                       rec_valid;
  logic                       rec_ready;
  nrc_pkg::pkt_rec_t          rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zone <= zone_offset_seconds;
    end
  end

  nrc_capture u_capture (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .rec_valid    (rec_valid),
    .rec          (rec),
    .rec_ready    (rec_ready)
  );

  nrc_check u_check (
    .clk                (clk),
    .rst                (rst),
    .rec_valid          (rec_valid),
    .rec                (rec),
    .rec_ready          (rec_ready),
    .zone               (zone),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .time_valid         (time_valid),
    .check_status       (check_status),
    .local_unix_seconds (local_unix_seconds)
  );

endmodule

// File: hw/rtl/nrc_capture.sv
// Byte counter and field capture; hands a finished packet record to the check stage.
module nrc_capture (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        payload_byte,
  input  logic              last_byte,
  output logic              rec_valid,
  output nrc_pkg::pkt_rec_t rec,
  input  logic              rec_ready
);

  logic [nrc_pkg::COUNT_W-1:0] byte_count;
  logic [nrc_pkg::COUNT_W-1:0] byte_count_next;
  logic [7:0]                  header_byte;
  logic [7:0]                  header_next;
  logic [7:0]                  stratum_byte;
  logic [7:0]                  stratum_next;
  logic [31:0]                 timestamp_shift;
  logic [31:0]                 timestamp_next;
  logic                        accept;

  assign in_ready = !rec_valid || rec_ready;
  assign accept = in_valid && in_ready;

  always_comb begin
    header_next = header_byte;
    stratum_next = stratum_byte;
    timestamp_next = timestamp_shift;
    if (byte_count == nrc_pkg::HDR_POS) begin
      header_next = payload_byte;
    end else if (byte_count == nrc_pkg::STRATUM_POS) begin
      stratum_next = payload_byte;
    end else if (byte_count >= nrc_pkg::TS_FIRST && byte_count <= nrc_pkg::TS_LAST) begin
      timestamp_next = {timestamp_shift[23:0], payload_byte};
    end
    if (byte_count < nrc_pkg::PKT_LEN) begin
      byte_count_next = byte_count + nrc_pkg::COUNT_W'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (accept) begin
        byte_count <= last_byte ? '0 : byte_count_next;
      end
      if (accept && last_byte) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_byte <= header_next;
      stratum_byte <= stratum_next;
      timestamp_shift <= timestamp_next;
    end
    if (accept && last_byte) begin
      rec.full <= (byte_count_next == nrc_pkg::PKT_LEN);
      rec.header <= header_next;
      rec.stratum <= stratum_next;
      rec.timestamp <= timestamp_next;
    end
  end

endmodule

// File: hw/rtl/nrc_check.sv
// Length, header, stratum and timestamp checks and local time computation into the result register.
module nrc_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rec_valid,
  input  nrc_pkg::pkt_rec_t           rec,
  output logic                        rec_ready,
  input  logic [nrc_pkg::ZONE_W-1:0]  zone,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        time_valid,
  output logic [2:0]                  check_status,
  output logic [31:0]                 local_unix_seconds
);

  nrc_pkg::status_t status;
  logic [31:0]      zone_word;
  logic [31:0]      local_time;

  assign rec_ready = !out_valid || out_ready;
  assign zone_word = {{(32 - nrc_pkg::ZONE_W){zone[nrc_pkg::ZONE_W-1]}}, zone};
  assign local_time = rec.timestamp - nrc_pkg::UNIX_EPOCH_OFFSET + zone_word;

  always_comb begin
    if (!rec.full) begin
      status = nrc_pkg::ST_SHORT;
    end else if (rec.header[2:0] != nrc_pkg::MODE_SERVER) begin
      status = nrc_pkg::ST_MODE;
    end else if (rec.header[5:3] < nrc_pkg::MIN_VERSION) begin
      status = nrc_pkg::ST_VERSION;
    end else if (rec.header[7:6] == nrc_pkg::LEAP_ALARM) begin
      status = nrc_pkg::ST_LEAP;
    end else if (rec.stratum == 8'd0) begin
      status = nrc_pkg::ST_STRATUM;
    end else if (rec.timestamp == 32'd0) begin
      status = nrc_pkg::ST_ZERO_TS;
    end else begin
      status = nrc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready && rec_valid) begin
      time_valid <= (status == nrc_pkg::ST_OK);
      check_status <= status;
      local_unix_seconds <= (status == nrc_pkg::ST_OK) ? local_time : 32'd0;
    end
  end

endmodule

// File: tb/sv/tb_ntp_response_checker_unit.sv
// Self-checking testbench for the NTP response checker: directed and random packets, scoreboard.
`timescale 1ns / 1ps

module tb_ntp_response_checker_unit;
  import nrc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic        time_ok;
    status_t     status;
    logic [31:0] seconds;
  } ntp_result_t;

  class ntp_time_predictor;
    logic [COUNT_W-1:0] seen;
    logic [7:0] hdr;
    logic [7:0] strat;
    logic [31:0] ts_word;
    logic signed [ZONE_W-1:0] zone;
    ntp_result_t pending_times[$];
    int mismatches;

    function new();
      zone = '0;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      seen = '0;
      hdr = '0;
      strat = '0;
      ts_word = '0;
    endfunction

    function void set_zone(logic signed [ZONE_W-1:0] z);
      zone = z;
    endfunction

    function int pending();
      return pending_times.size();
    endfunction

    function void take_byte(logic [7:0] b, logic is_last);
      ntp_result_t r;
      status_t st;
      if (seen == HDR_POS) begin
        hdr = b;
      end else if (seen == STRATUM_POS) begin
        strat = b;
      end else if (seen >= TS_FIRST && seen <= TS_LAST) begin
        ts_word = {ts_word[23:0], b};
      end
      if (seen < PKT_LEN) begin
        seen = seen + 1'b1;
      end
      if (!is_last) begin
        return;
      end
      if (seen < PKT_LEN) begin
        st = ST_SHORT;
      end else if (hdr[2:0] != MODE_SERVER) begin
        st = ST_MODE;
      end else if (hdr[5:3] < MIN_VERSION) begin
        st = ST_VERSION;
      end else if (hdr[7:6] == LEAP_ALARM) begin
        st = ST_LEAP;
      end else if (strat == 8'd0) begin
        st = ST_STRATUM;
      end else if (ts_word == 32'd0) begin
        st = ST_ZERO_TS;
      end else begin
        st = ST_OK;
      end
      r.status = st;
      r.time_ok = (st == ST_OK);
      r.seconds = (st == ST_OK) ?
          ts_word - UNIX_EPOCH_OFFSET + {{(32 - ZONE_W){zone[ZONE_W-1]}}, zone} : 32'd0;
      pending_times.push_back(r);
      clear();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      mismatches++;
    endtask

    task check_result(logic tv, logic [2:0] st, logic [31:0] secs);
      ntp_result_t r;
      if (pending_times.size() == 0) begin
        report("unexpected result beat", {29'd0, st}, 32'd0);
        return;
      end
      r = pending_times.pop_front();
      if (tv !== r.time_ok) begin
        report("time_valid", {31'd0, tv}, {31'd0, r.time_ok});
      end
      if (st !== r.status) begin
        report("check_status", {29'd0, st}, {29'd0, r.status});
      end
      if (secs !== r.seconds) begin
        report("local_unix_seconds", secs, r.seconds);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] payload_byte;
  logic last_byte;
  logic out_valid;
  logic out_ready;
  logic time_valid;
  logic [2:0] check_status;
  logic [31:0] local_unix_seconds;
  logic cfg_valid;
  logic cfg_ready;
  logic signed [ZONE_W-1:0] zone_offset;

  ntp_time_predictor board;
  int tx_idle_pct = 29;
  int rx_idle_pct = 29;
  bit hold_req = 1'b0;
  int n_bytes = 0;
  int n_results = 0;
  int quiet_cycles = 0;

  ntp_response_checker_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .payload_byte(payload_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .time_valid(time_valid),
    .check_status(check_status),
    .local_unix_seconds(local_unix_seconds),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .zone_offset_seconds(zone_offset)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        board.take_byte(payload_byte, last_byte);
        n_bytes++;
      end
      if (cfg_valid && cfg_ready) begin
        board.set_zone(zone_offset);
      end
      if (out_valid && out_ready) begin
        board.check_result(time_valid, check_status, local_unix_seconds);
        n_results++;
      end
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // The receiver either stalls at random or, on request, holds off for a long stretch.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    payload_byte <= b;
    last_byte <= is_last;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    @(negedge clk);
  endtask

  task send_packet(int len, logic [7:0] hdr, logic [7:0] strat, logic [31:0] ts);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = hdr;
      end else if (i == 1) begin
        b = strat;
      end else if (i >= 40 && i <= 43) begin
        b = ts[8*(43-i) +: 8];
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, i == len - 1);
    end
  endtask

  task write_zone(logic signed [ZONE_W-1:0] z);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    zone_offset <= z;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_random_packet();
    int len;
    logic [7:0] hdr;
    logic [7:0] strat;
    logic [31:0] ts;
    if ($urandom_range(99) < 75) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(49, 64) : 48;
      hdr = {2'($urandom_range(2)), 3'($urandom_range(3, 7)), MODE_SERVER};
      strat = 8'($urandom_range(1, 255));
      ts = $urandom;
      if ($urandom_range(99) < 30) begin
        case ($urandom_range(5))
          0: len = $urandom_range(1, 47);
          1: begin
            hdr[2:0] = 3'($urandom);
            if (hdr[2:0] == MODE_SERVER) hdr[2:0] = ~MODE_SERVER;
          end
          2: hdr[5:3] = 3'($urandom_range(0, 2));
          3: hdr[7:6] = LEAP_ALARM;
          4: strat = 8'd0;
          default: ts = 32'd0;
        endcase
      end
    end else begin
      len = $urandom_range(1, 64);
      hdr = 8'($urandom);
      strat = 8'($urandom);
      ts = $urandom;
    end
    send_packet(len, hdr, strat, ts);
  endtask

  initial begin
    logic signed [ZONE_W-1:0] z;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    payload_byte = '0;
    last_byte = 1'b0;
    cfg_valid = 1'b0;
    zone_offset = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No idling on either side through the failing packets.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_packet(47, 8'h24, 8'd1, 32'hE500_0000);
    send_packet(48, 8'h23, 8'd1, 32'hE500_0000);
    send_packet(48, 8'h14, 8'd1, 32'hE500_0000);
    send_packet(48, 8'hE4, 8'd1, 32'hE500_0000);
    send_packet(48, 8'h24, 8'd0, 32'hE500_0000);
    send_packet(48, 8'h24, 8'd1, 32'd0);
    tx_idle_pct = 29;
    rx_idle_pct = 29;

    write_zone(-17'sd43200);
    send_packet(52, 8'hA4, 8'd2, UNIX_EPOCH_OFFSET + 32'd5);
    write_zone(17'sd50400);
    send_packet(48, 8'h1C, 8'd255, UNIX_EPOCH_OFFSET - 32'd1);

    // Long receiver hold-off while one-byte packets keep coming, so the input backs up.
    hold_req = 1'b1;
    tx_idle_pct = 0;
    for (int i = 0; i < 16; i++) begin
      send_byte(8'($urandom), 1'b1);
    end
    tx_idle_pct = 29;

    while (n_bytes < 440) begin
      z = 17'($urandom_range(0, 93600) - 43200);
      write_zone(z);
      send_random_packet();
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.pending() != 0) begin
      board.report("results never delivered", board.pending(), 32'd0);
    end
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
